/* sv/ddpp_pkg.sv */
// ----------------------------------------------------------------------------
// ddpp_pkg
// Shared widths, protocol constants and transfer types of the DDP pixel
// packetizer.
// ----------------------------------------------------------------------------
package ddpp_pkg;

  // default packet size in pixels
  localparam int unsigned DEF_PIXELS_PER_PACKET = 480;

  // field widths
  localparam int IDX_W   = 20;
  localparam int CNT_W   = 21;
  localparam int START_W = 25;
  localparam int OFS_W   = 32;
  localparam int LEN_W   = 16;

  // colour channels per pixel
  localparam int CH_PER_PIXEL = 3;

  // register reset values
  localparam logic [CNT_W-1:0]   RST_PIXEL_COUNT   = 21'd480;
  localparam logic [START_W-1:0] RST_START_CHANNEL = 25'd1;

  // register indexes on the configuration port
  localparam logic REG_PIXEL_COUNT   = 1'b0;
  localparam logic REG_START_CHANNEL = 1'b1;

  // header constants
  localparam logic [7:0] FLAG_VERSION1 = 8'h40;
  localparam logic [7:0] FLAG_PUSH     = 8'h01;
  localparam logic [7:0] SEQ_NUM       = 8'h00;
  localparam logic [7:0] TYPE_RGB      = 8'h01;
  localparam logic [7:0] DEST_DISPLAY  = 8'h01;

  // byte positions within one pixel's share of the stream
  typedef enum logic [3:0] {
    POS_FLAGS,
    POS_SEQ,
    POS_TYPE,
    POS_DEST,
    POS_OFS3,
    POS_OFS2,
    POS_OFS1,
    POS_OFS0,
    POS_LEN1,
    POS_LEN0,
    POS_RED,
    POS_GREEN,
    POS_BLUE
  } byte_pos_t;

  // input transfer
  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } pixel_t;

  // output transfer
  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_start;
    logic       packet_end;
    logic       bad_index;
    logic       run_last;
  } result_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [CNT_W-1:0]   pixel_count;
    logic [START_W-1:0] start_channel;
  } cfg_t;

  // mapped pixel handed to the serialiser
  typedef struct packed {
    logic             bad;
    logic             is_last;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] base;
    logic [OFS_W-1:0] chan;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } map_item_t;

endpackage

/* sv/ddp_pixel_packetizer.sv */
// ----------------------------------------------------------------------------
// ddp_pixel_packetizer
// Turns indexed RGB pixels into a DDP packet byte stream with header bytes
// ahead of each packet-opening pixel; register block on an APB-style port.
// ----------------------------------------------------------------------------
// bytes: each pixel yields its red, green and blue bytes, a packet-opening
// pixel also ten header bytes ahead of them, and a bad index one zero byte; the
//   pace is set by the byte-wide output serialiser
// reset: pixel_count 480, start_channel 1, pipeline and output emptied
// ----------------------------------------------------------------------------
module ddp_pixel_packetizer
  import ddpp_pkg::*;
#(
  parameter int unsigned PIXELS_PER_PACKET = DEF_PIXELS_PER_PACKET
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        pix_valid,
  output logic        pix_ready,
  input  pixel_t      pix,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);

  logic [CNT_W-1:0]   pixel_count;
  logic [START_W-1:0] start_channel;
  cfg_t               cfg;
  logic               item_valid, item_ready;
  map_item_t          item;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count   <= RST_PIXEL_COUNT;
      start_channel <= RST_START_CHANNEL;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_PIXEL_COUNT:   pixel_count   <= pwdata[CNT_W-1:0];
        REG_START_CHANNEL: start_channel <= pwdata[START_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[2])
      REG_PIXEL_COUNT:   prdata = 32'(pixel_count);
      REG_START_CHANNEL: prdata = 32'(start_channel);
      default:           prdata = 32'h0;
    endcase
  end

  assign cfg.pixel_count   = pixel_count;
  assign cfg.start_channel = start_channel;

  ddpp_index_map #(
    .PIXELS_PER_PACKET(PIXELS_PER_PACKET)
  ) u_map (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix        (pix),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  ddpp_byte_serializer #(
    .PIXELS_PER_PACKET(PIXELS_PER_PACKET)
  ) u_ser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // input only stalls when the whole pipeline is backed up
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> (item_valid && !item_ready))
    else $error("input stalled with room in the pipeline");

  // packet base lies within one packet of the pixel index
  a_base_range: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && !item.bad) |->
      ((item.base <= item.idx) &&
       ((item.idx - item.base) < CNT_W'(PIXELS_PER_PACKET))))
    else $error("packet base out of range");

  // a packet closes only on the final byte of a good pixel
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.packet_end) |-> (res.run_last && !res.bad_index))
    else $error("packet end on a non-final byte");

  // a packet start is never the final byte of a pixel
  a_start_not_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.packet_start) |-> (!res.run_last && !res.bad_index))
    else $error("packet start on a final byte");

endmodule

/* sv/ddpp_index_map.sv */
// ----------------------------------------------------------------------------
// ddpp_index_map
// Input register and two stages that split the pixel index into packet
// number and packet base, and work out channel offset and last-packet flag.
// ----------------------------------------------------------------------------
module ddpp_index_map
  import ddpp_pkg::*;
#(
  parameter int unsigned PIXELS_PER_PACKET = DEF_PIXELS_PER_PACKET
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      pix_valid,
  output logic      pix_ready,
  input  pixel_t    pix,
  output logic      item_valid,
  input  logic      item_ready,
  output map_item_t item
);

  // reciprocal for exact division by the packet size over CNT_W-bit values
  localparam int unsigned SH     = CNT_W + $clog2(PIXELS_PER_PACKET);
  localparam int unsigned PROD_W = SH + CNT_W;
  localparam logic [63:0] RECIP  =
    ((64'd1 << SH) + 64'(PIXELS_PER_PACKET) - 64'd1) / 64'(PIXELS_PER_PACKET);
  localparam logic [PROD_W-1:0] RECIP_C = PROD_W'(RECIP);
  localparam logic [CNT_W-1:0]  PPP_C   = CNT_W'(PIXELS_PER_PACKET);
  localparam logic [OFS_W-1:0]  CH_PKT  = OFS_W'(CH_PER_PIXEL * PIXELS_PER_PACKET);

  logic               v0, v1, v2;
  logic               adv0, adv1, adv2;
  logic [IDX_W-1:0]   idx0;
  logic [7:0]         r0, g0, b0;
  logic               bad1;
  logic [CNT_W-1:0]   idx1, packet1;
  logic [7:0]         r1, g1, b1;
  logic [CNT_W-1:0]   last_packet;
  logic [PROD_W-1:0]  quot_prod, last_prod;
  logic [2*CNT_W-1:0] base_prod;
  logic [OFS_W-1:0]   chan_next;
  logic [CNT_W-1:0]   pcm1;

  // stall chain
  assign adv2      = !v2 || item_ready;
  assign adv1      = !v1 || adv2;
  assign adv0      = !v0 || adv1;
  assign pix_ready = adv0;

  // packet number of the last packet, follows the pixel count register
  assign pcm1      = cfg.pixel_count - CNT_W'(1);
  assign last_prod = PROD_W'(pcm1) * RECIP_C;

  always_ff @(posedge clk) begin
    last_packet <= last_prod[SH +: CNT_W];
  end

  // packet number of the incoming pixel
  assign quot_prod = PROD_W'(idx0) * RECIP_C;

  // packet base and channel offset
  assign base_prod = packet1 * PPP_C;
  assign chan_next = OFS_W'(packet1) * CH_PKT;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv0) v0 <= pix_valid;
      if (adv1) v1 <= v0;
      if (adv2) v2 <= v1;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv0) begin
      idx0 <= pix.pixel_index;
      r0   <= pix.red;
      g0   <= pix.green;
      b0   <= pix.blue;
    end
    if (adv1) begin
      bad1    <= CNT_W'(idx0) >= cfg.pixel_count;
      idx1    <= CNT_W'(idx0);
      packet1 <= quot_prod[SH +: CNT_W];
      r1      <= r0;
      g1      <= g0;
      b1      <= b0;
    end
    if (adv2) begin
      item.bad     <= bad1;
      item.is_last <= packet1 == last_packet;
      item.idx     <= idx1;
      item.base    <= base_prod[CNT_W-1:0];
      item.chan    <= chan_next;
      item.red     <= r1;
      item.green   <= g1;
      item.blue    <= b1;
    end
  end

  assign item_valid = v2;

endmodule

/* sv/ddpp_byte_serializer.sv */
// ----------------------------------------------------------------------------
// ddpp_byte_serializer
// Holds one mapped pixel, forms its header fields and walks its bytes out
// through a registered output stage.
// ----------------------------------------------------------------------------
module ddpp_byte_serializer
  import ddpp_pkg::*;
#(
  parameter int unsigned PIXELS_PER_PACKET = DEF_PIXELS_PER_PACKET
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      item_valid,
  output logic      item_ready,
  input  map_item_t item,
  output logic      res_valid,
  input  logic      res_ready,
  output result_t   res
);

  localparam logic [CNT_W-1:0] SLOT_LAST = CNT_W'(PIXELS_PER_PACKET - 1);
  localparam logic [LEN_W-1:0] LEN_FULL  = LEN_W'(CH_PER_PIXEL * PIXELS_PER_PACKET);

  logic             hv, hbad, hcloses;
  logic [7:0]       hflags, hred, hgreen, hblue;
  logic [OFS_W-1:0] hoff;
  logic [LEN_W-1:0] hlen;
  byte_pos_t        pos, pos_start;
  logic             ov;
  logic             emit, last_byte;
  logic [CNT_W-1:0] rel, diff, pcm1;
  logic             opens, closes_next;
  logic [LEN_W-1:0] len_next;
  logic [OFS_W-1:0] off_next;
  logic [7:0]       flags_next;
  logic [7:0]       byte_sel;
  result_t          res_next;

  // header fields of the incoming pixel
  assign rel         = item.idx - item.base;
  assign pcm1        = cfg.pixel_count - CNT_W'(1);
  assign diff        = cfg.pixel_count - item.base;
  assign opens       = rel == '0;
  assign closes_next = (rel == SLOT_LAST) || (item.idx == pcm1);
  // full length in channels, or three channels per remaining pixel of the last packet
  assign len_next    = item.is_last ? LEN_W'({diff, 1'b0} + {1'b0, diff}) : LEN_FULL;
  assign off_next    = OFS_W'(cfg.start_channel) - OFS_W'(1) + item.chan;
  assign flags_next  = item.is_last ? (FLAG_VERSION1 | FLAG_PUSH) : FLAG_VERSION1;
  assign pos_start   = opens ? POS_FLAGS : POS_RED;

  // byte transfer control
  assign emit       = hv && (!ov || res_ready);
  assign last_byte  = hbad || (pos == POS_BLUE);
  assign item_ready = !hv || (emit && last_byte);

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
    end else if (item_ready) begin
      hv <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) begin
      hbad    <= item.bad;
      hcloses <= closes_next;
      hflags  <= flags_next;
      hoff    <= off_next;
      hlen    <= len_next;
      hred    <= item.red;
      hgreen  <= item.green;
      hblue   <= item.blue;
      pos     <= pos_start;
    end else if (emit) begin
      pos <= byte_pos_t'(pos + 4'd1);
    end
  end

  // byte select
  always_comb begin
    case (pos)
      POS_FLAGS: byte_sel = hflags;
      POS_SEQ:   byte_sel = SEQ_NUM;
      POS_TYPE:  byte_sel = TYPE_RGB;
      POS_DEST:  byte_sel = DEST_DISPLAY;
      POS_OFS3:  byte_sel = hoff[31:24];
      POS_OFS2:  byte_sel = hoff[23:16];
      POS_OFS1:  byte_sel = hoff[15:8];
      POS_OFS0:  byte_sel = hoff[7:0];
      POS_LEN1:  byte_sel = hlen[15:8];
      POS_LEN0:  byte_sel = hlen[7:0];
      POS_RED:   byte_sel = hred;
      POS_GREEN: byte_sel = hgreen;
      POS_BLUE:  byte_sel = hblue;
      default:   byte_sel = 8'h00;
    endcase
  end

  // result word, an error result carries a zero byte
  always_comb begin
    res_next.out_byte     = hbad ? 8'h00 : byte_sel;
    res_next.packet_start = !hbad && (pos == POS_FLAGS);
    res_next.packet_end   = !hbad && (pos == POS_BLUE) && hcloses;
    res_next.bad_index    = hbad;
    res_next.run_last     = last_byte;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (emit) begin
      ov <= 1'b1;
    end else if (res_ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_next;
    end
  end

  assign res_valid = ov;

endmodule
